/* hdl/fct_pkg.sv */
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and codes for the frequency count table: request and response
// payloads, action codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package fct_pkg;

	localparam int ACTION_BITS  = 2;
	localparam int OPERAND_BITS = 12;

	localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_QUERY  = 2'd2;

	typedef struct packed {
		logic [ACTION_BITS-1:0]  action;
		logic [OPERAND_BITS-1:0] operand;
	} fct_req_t;

	typedef struct packed {
		logic found;
	} fct_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_DEC,
		ST_INC,
		ST_QRESP
	} fct_state_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic upd;
		logic dec;
		logic inc;
		logic load;
	} fct_cmd_t;

	typedef struct packed {
		logic [ACTION_BITS-1:0] act;
		logic                   clr_last;
		logic                   out_busy;
	} fct_sts_t;

endpackage

/* hdl/fct_stream_if.sv */
// ----------------------------------------------------------------------------
// fct_stream_if
// Valid/ready channel carrying one payload; a request moves when both are high.
// ----------------------------------------------------------------------------
interface fct_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/frequency_count_table_core.sv */
// ----------------------------------------------------------------------------
// frequency_count_table_core
// Per-key counts plus, per count, the number of keys holding it.
// ----------------------------------------------------------------------------
// After reset the block sweeps both tables to zero, one entry per cycle over
// 2^max(KEY_BITS, COUNT_BITS) entries, with req.ready low. It then takes one
// request at a time: an insert or delete passes from acceptance to the next
// ready through count read, count write-back with old-bucket read, old-bucket
// write with new-bucket read, and new-bucket write, since both tables are
// memories with one read and one write port and registered reads. A query
// reads its bucket and places its found bit in the output register, waiting
// to load it only while the previous response is still held. Inserts and
// deletes give no response; action code 3 is taken and dropped.
// ----------------------------------------------------------------------------
module frequency_count_table_core #(
	parameter int KEY_BITS   = 12,
	parameter int COUNT_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	fct_stream_if.sink   req,
	fct_stream_if.source rsp
);
	import fct_pkg::*;

	fct_cmd_t cmd;
	fct_sts_t sts;

	fct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fct_dp #(
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.rsp_ready (rsp.ready)
	);

endmodule

/* hdl/fct_ctrl.sv */
// ----------------------------------------------------------------------------
// fct_ctrl
// Controller: clearing sweep after reset, then one request at a time through
// read, bucket decrement and bucket increment, or query response.
// ----------------------------------------------------------------------------
module fct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fct_pkg::fct_sts_t sts,
	output fct_pkg::fct_cmd_t cmd
);
	import fct_pkg::*;

	fct_state_t state_q;
	fct_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					case (sts.act)
						ACT_INSERT, ACT_DELETE: state_d = ST_UPD;
						ACT_QUERY:              state_d = ST_QRESP;
						default:                state_d = ST_IDLE;
					endcase
				end
			end
			ST_UPD:   state_d = ST_DEC;
			ST_DEC:   state_d = ST_INC;
			ST_INC:   state_d = ST_IDLE;
			ST_QRESP: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_UPD:   cmd.upd  = 1'b1;
			ST_DEC:   cmd.dec  = 1'b1;
			ST_INC:   cmd.inc  = 1'b1;
			ST_QRESP: cmd.load = !sts.out_busy;
			default: begin
				cmd       = '0;
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

/* hdl/fct_dp.sv */
// ----------------------------------------------------------------------------
// fct_dp
// Datapath: per-key count table, per-count bucket table, request latches and
// the response register.
// ----------------------------------------------------------------------------
module fct_dp #(
	parameter int KEY_BITS   = 12,
	parameter int COUNT_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fct_pkg::fct_req_t req_data,
	input  fct_pkg::fct_cmd_t cmd,
	output fct_pkg::fct_sts_t sts,
	output logic              rsp_valid,
	output fct_pkg::fct_rsp_t rsp_data,
	input  logic              rsp_ready
);
	import fct_pkg::*;

	localparam int SWEEP_BITS = (KEY_BITS > COUNT_BITS) ? KEY_BITS : COUNT_BITS;
	localparam int KWC_BITS   = KEY_BITS + 1;
	localparam int KEY_DEPTH  = 1 << KEY_BITS;
	localparam int CNT_DEPTH  = 1 << COUNT_BITS;

	logic [COUNT_BITS-1:0] kc_mem [KEY_DEPTH];
	logic [KWC_BITS-1:0]   kwc_mem [CNT_DEPTH];

	logic [SWEEP_BITS-1:0] sweep_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] want_q;
	logic                  ins_q;
	logic [COUNT_BITS-1:0] old_q;
	logic [COUNT_BITS-1:0] new_q;
	logic                  chg_q;
	logic [COUNT_BITS-1:0] kc_rd_q;
	logic [KWC_BITS-1:0]   kwc_rd_q;
	logic                  out_valid_q;
	logic                  found_q;

	logic [KEY_BITS-1:0]   key_in;
	logic [COUNT_BITS-1:0] want_in;
	logic                  chg;
	logic [COUNT_BITS-1:0] new_cnt;

	logic                  kc_we;
	logic [KEY_BITS-1:0]   kc_waddr;
	logic [COUNT_BITS-1:0] kc_wdata;
	logic                  kwc_we;
	logic [COUNT_BITS-1:0] kwc_waddr;
	logic [KWC_BITS-1:0]   kwc_wdata;
	logic [COUNT_BITS-1:0] kwc_raddr;

	assign key_in  = KEY_BITS'(req_data.operand);
	assign want_in = COUNT_BITS'(req_data.operand);

	// saturate at the top count, hold at zero
	assign chg     = ins_q ? (kc_rd_q != '1) : (kc_rd_q != '0);
	assign new_cnt = ins_q ? (kc_rd_q + COUNT_BITS'(1)) : (kc_rd_q - COUNT_BITS'(1));

	always_comb begin
		kc_we    = cmd.clr | (cmd.upd & chg);
		kc_waddr = cmd.clr ? KEY_BITS'(sweep_q) : key_q;
		kc_wdata = cmd.clr ? '0 : new_cnt;
	end

	always_comb begin
		kwc_we    = 1'b0;
		kwc_waddr = new_q;
		kwc_wdata = kwc_rd_q + KWC_BITS'(1);
		if (cmd.clr) begin
			kwc_we    = 1'b1;
			kwc_waddr = COUNT_BITS'(sweep_q);
			kwc_wdata = '0;
		end else if (cmd.dec) begin
			kwc_we    = chg_q && (old_q != '0) && (kwc_rd_q != '0);
			kwc_waddr = old_q;
			kwc_wdata = kwc_rd_q - KWC_BITS'(1);
		end else if (cmd.inc) begin
			kwc_we    = chg_q && (new_q != '0);
		end
	end

	// old bucket during update, new bucket during decrement, else the query count
	always_comb begin
		if (cmd.upd) begin
			kwc_raddr = kc_rd_q;
		end else if (cmd.dec) begin
			kwc_raddr = new_q;
		end else if (cmd.accept) begin
			kwc_raddr = want_in;
		end else begin
			kwc_raddr = want_q;
		end
	end

	always_ff @(posedge clk) begin
		if (kc_we) kc_mem[kc_waddr] <= kc_wdata;
		kc_rd_q <= kc_mem[key_in];
	end

	always_ff @(posedge clk) begin
		if (kwc_we) kwc_mem[kwc_waddr] <= kwc_wdata;
		kwc_rd_q <= kwc_mem[kwc_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.clr) begin
			sweep_q <= sweep_q + SWEEP_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q  <= key_in;
			want_q <= want_in;
			ins_q  <= (req_data.action == ACT_INSERT);
		end
		if (cmd.upd) begin
			old_q <= kc_rd_q;
			new_q <= new_cnt;
			chg_q <= chg;
		end
		if (cmd.load) begin
			found_q <= (want_q != '0) && (kwc_rd_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_data.found = found_q;

	assign sts.act      = req_data.action;
	assign sts.clr_last = &sweep_q;
	assign sts.out_busy = out_valid_q & ~rsp_ready;

endmodule

/* hdl/fct_checker.sv */
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks on request sequencing and response timing.
// ----------------------------------------------------------------------------
module fct_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic [fct_pkg::ACTION_BITS-1:0]     req_action,
	input logic                                rsp_valid,
	input logic                                rsp_ready
);
	import fct_pkg::*;

	logic req_take;
	logic is_update;

	assign req_take  = req_valid & req_ready;
	assign is_update = (req_action == ACT_INSERT) || (req_action == ACT_DELETE);

	// one request in flight at a time; the unused code is dropped on the spot
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (is_update || (req_action == ACT_QUERY)) |=> !req_ready)
		else $error("request accepted while previous one still in work");

	// updates never produce a response
	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && is_update && !rsp_valid |=> !rsp_valid)
		else $error("response raised by insert or delete");

	// a query with a free output slot answers through the response state and the output register
	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req_action == ACT_QUERY) && !rsp_valid |-> ##2 rsp_valid)
		else $error("query response missing");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before taken");

endmodule

bind frequency_count_table_core fct_checker u_fct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.data.action),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready)
);
